>>> hdl/corexy_gantry_step_controller_macros.svh
// assertion helpers shared by the gantry controller
`ifndef COREXY_GANTRY_STEP_CONTROLLER_MACROS_SVH
`define COREXY_GANTRY_STEP_CONTROLLER_MACROS_SVH

// checked outside reset only
`define CXG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define CXG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/cxg_pkg.sv
`default_nettype none
package cxg_pkg;

  localparam int unsigned PosW   = 12;
  localparam int unsigned DistW  = 11;
  localparam int unsigned SpmW   = 8;
  localparam int unsigned StepsW = 18;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_HOME   = 2'd1,
    ACT_MOVE_X = 2'd2,
    ACT_MOVE_Y = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_HOME = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_IGNORED = 2'd2
  } status_e;

  // register indexes on the config port
  localparam logic [CfgAddrW-1:0] REG_MIN_X = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_MAX_X = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_MIN_Y = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_MAX_Y = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_SPM   = 3'd4;

  localparam logic signed [PosW-1:0] RST_MIN_X = 12'sd0;
  localparam logic signed [PosW-1:0] RST_MAX_X = 12'sd400;
  localparam logic signed [PosW-1:0] RST_MIN_Y = 12'sd0;
  localparam logic signed [PosW-1:0] RST_MAX_Y = 12'sd400;
  localparam logic [SpmW-1:0]        RST_SPM   = 8'd80;

  // direction pairs, bit 0 motor one, bit 1 motor two
  localparam logic [1:0] DIR_X_FWD  = 2'b00;
  localparam logic [1:0] DIR_X_BACK = 2'b11;
  localparam logic [1:0] DIR_Y_FWD  = 2'b01;
  localparam logic [1:0] DIR_Y_BACK = 2'b10;
  localparam logic [1:0] DIR_HOME_Y = 2'b11;
  localparam logic [1:0] DIR_HOME_X = 2'b10;

  typedef struct packed {
    logic signed [PosW-1:0] min_x;
    logic signed [PosW-1:0] max_x;
    logic signed [PosW-1:0] min_y;
    logic signed [PosW-1:0] max_y;
    logic [SpmW-1:0]        spm;
  } cfg_t;

  typedef struct packed {
    action_e                 action;
    logic signed [DistW-1:0] dist_mm;
    logic                    lim_x;
    logic                    lim_y;
  } item_t;

  typedef struct packed {
    logic signed [PosW-1:0] x_pos;
    logic signed [PosW-1:0] y_pos;
    logic [StepsW-1:0]      steps;
    mode_e                  mode;
    logic [1:0]             dir;
    logic                   awake;
  } state_t;

  typedef struct packed {
    logic                   pulse;
    logic                   dir1;
    logic                   dir2;
    logic                   awake;
    logic                   busy;
    status_e                status;
    logic signed [PosW-1:0] x_pos;
    logic signed [PosW-1:0] y_pos;
  } res_t;

endpackage
`default_nettype wire

>>> hdl/cxg_step_core.sv
`default_nettype none
// next-state and result logic for one beat
module cxg_step_core (
  input  cxg_pkg::cfg_t   cfg_i,
  input  cxg_pkg::state_t st_i,
  input  cxg_pkg::item_t  item_i,
  output cxg_pkg::state_t st_o,
  output cxg_pkg::res_t   res_o
);

  always_comb begin
    logic                                  busy;
    logic                                  is_x;
    logic signed [cxg_pkg::PosW-1:0]       pos;
    logic signed [cxg_pkg::PosW-1:0]       lo;
    logic signed [cxg_pkg::PosW-1:0]       hi;
    logic signed [cxg_pkg::PosW:0]         np;
    logic [cxg_pkg::DistW-1:0]             mag;
    logic [cxg_pkg::SpmW+cxg_pkg::DistW-1:0] prod;
    logic [cxg_pkg::StepsW-1:0]            cnt;
    logic [cxg_pkg::StepsW-1:0]            dec;
    logic                                  pulse;
    cxg_pkg::status_e                      status;

    st_o   = st_i;
    pulse  = 1'b0;
    status = cxg_pkg::STAT_OK;
    busy   = (st_i.mode != cxg_pkg::MODE_IDLE);
    is_x   = (item_i.action == cxg_pkg::ACT_MOVE_X);
    pos    = is_x ? st_i.x_pos : st_i.y_pos;
    lo     = is_x ? cfg_i.min_x : cfg_i.min_y;
    hi     = is_x ? cfg_i.max_x : cfg_i.max_y;
    // new position one bit wider so it never wraps
    np     = $signed({pos[cxg_pkg::PosW-1], pos})
           + $signed({{2{item_i.dist_mm[cxg_pkg::DistW-1]}}, item_i.dist_mm});
    mag    = item_i.dist_mm[cxg_pkg::DistW-1] ? (~item_i.dist_mm + 1'b1) : item_i.dist_mm;
    prod   = (cxg_pkg::SpmW+cxg_pkg::DistW)'(cfg_i.spm)
           * (cxg_pkg::SpmW+cxg_pkg::DistW)'(mag);
    // halve with round up
    cnt    = cxg_pkg::StepsW'((prod + 1'b1) >> 1);
    dec    = st_i.steps - 1'b1;

    if (item_i.action != cxg_pkg::ACT_TICK) begin
      if (busy) begin
        status = cxg_pkg::STAT_IGNORED;
      end else if (item_i.action == cxg_pkg::ACT_HOME) begin
        if (item_i.lim_x && item_i.lim_y) begin
          st_o.x_pos = '0;
          st_o.y_pos = '0;
          st_o.awake = 1'b0;
          st_o.mode  = cxg_pkg::MODE_IDLE;
        end else begin
          st_o.awake = 1'b1;
          st_o.mode  = cxg_pkg::MODE_HOME;
        end
      end else if ((np > $signed({hi[cxg_pkg::PosW-1], hi}))
                || (np < $signed({lo[cxg_pkg::PosW-1], lo}))) begin
        status = cxg_pkg::STAT_RANGE;
      end else begin
        if (is_x) begin
          st_o.x_pos = np[cxg_pkg::PosW-1:0];
          st_o.dir   = item_i.dist_mm[cxg_pkg::DistW-1] ? cxg_pkg::DIR_X_BACK
                                                        : cxg_pkg::DIR_X_FWD;
        end else begin
          st_o.y_pos = np[cxg_pkg::PosW-1:0];
          st_o.dir   = item_i.dist_mm[cxg_pkg::DistW-1] ? cxg_pkg::DIR_Y_BACK
                                                        : cxg_pkg::DIR_Y_FWD;
        end
        st_o.steps = cnt;
        if (cnt != '0) begin
          st_o.awake = 1'b1;
          st_o.mode  = cxg_pkg::MODE_MOVE;
        end else begin
          st_o.awake = 1'b0;
          st_o.mode  = cxg_pkg::MODE_IDLE;
        end
      end
    end else begin
      case (st_i.mode)
        cxg_pkg::MODE_MOVE: begin
          if (st_i.steps != '0) begin
            pulse      = 1'b1;
            st_o.steps = dec;
          end
          if (st_o.steps == '0) begin
            st_o.awake = 1'b0;
            st_o.mode  = cxg_pkg::MODE_IDLE;
          end
        end
        cxg_pkg::MODE_HOME: begin
          if (!item_i.lim_y) begin
            st_o.dir = cxg_pkg::DIR_HOME_Y;
            pulse    = 1'b1;
          end else if (!item_i.lim_x) begin
            st_o.dir = cxg_pkg::DIR_HOME_X;
            pulse    = 1'b1;
          end else begin
            st_o.x_pos = '0;
            st_o.y_pos = '0;
            st_o.awake = 1'b0;
            st_o.mode  = cxg_pkg::MODE_IDLE;
          end
        end
        default: begin
        end
      endcase
    end

    res_o.pulse  = pulse;
    res_o.dir1   = st_o.dir[0];
    res_o.dir2   = st_o.dir[1];
    res_o.awake  = st_o.awake;
    res_o.busy   = (st_o.mode != cxg_pkg::MODE_IDLE);
    res_o.status = status;
    res_o.x_pos  = st_o.x_pos;
    res_o.y_pos  = st_o.y_pos;
  end

endmodule
`default_nettype wire

>>> hdl/corexy_gantry_step_controller.sv
`default_nettype none
// CoreXY gantry step controller: each input beat is a tick, a homing start or a
// move along x or y, and yields exactly one result beat giving the step pulse,
// both motor directions, driver wake, busy, command status and the logical
// position after that beat. The block takes one beat per clock cycle while the
// result side does not stall; a beat waits in the input register, its state
// update and result are worked out in one pass through the step logic (one 8 by
// 11 bit multiply for the step count), and the result is then registered into
// the output register and offered from there. A stalled output holds the input
// register full, so at most two beats are in flight.
// Configuration is taken on any cycle with the write enable high and must only
// change while the block is idle.
`include "corexy_gantry_step_controller_macros.svh"
module corexy_gantry_step_controller (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // config write port
  input  wire logic                                cfg_we_i,
  input  wire logic [cxg_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  wire logic [cxg_pkg::CfgDataW-1:0]        cfg_wdata_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          action_i,
  input  wire logic signed [cxg_pkg::DistW-1:0]    distance_mm_i,
  input  wire logic                                limit_x_hit_i,
  input  wire logic                                limit_y_hit_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     step_pulse_o,
  output logic                                     motor1_dir_o,
  output logic                                     motor2_dir_o,
  output logic                                     drivers_awake_o,
  output logic                                     busy_res_o,
  output logic [1:0]                               command_status_o,
  output logic signed [cxg_pkg::PosW-1:0]          x_position_o,
  output logic signed [cxg_pkg::PosW-1:0]          y_position_o
);

  cxg_pkg::cfg_t   cfg_q;
  cxg_pkg::state_t state_q, state_d;
  cxg_pkg::item_t  item_q;
  cxg_pkg::res_t   res_q, res_d;
  logic            in_valid_q;
  logic            out_valid_q;
  logic            advance;

  // input beat moves on when the output register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_x <= cxg_pkg::RST_MIN_X;
      cfg_q.max_x <= cxg_pkg::RST_MAX_X;
      cfg_q.min_y <= cxg_pkg::RST_MIN_Y;
      cfg_q.max_y <= cxg_pkg::RST_MAX_Y;
      cfg_q.spm   <= cxg_pkg::RST_SPM;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        cxg_pkg::REG_MIN_X: cfg_q.min_x <= cfg_wdata_i;
        cxg_pkg::REG_MAX_X: cfg_q.max_x <= cfg_wdata_i;
        cxg_pkg::REG_MIN_Y: cfg_q.min_y <= cfg_wdata_i;
        cxg_pkg::REG_MAX_Y: cfg_q.max_y <= cfg_wdata_i;
        cxg_pkg::REG_SPM:   cfg_q.spm   <= cfg_wdata_i[cxg_pkg::SpmW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register, valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register, payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.action  <= cxg_pkg::action_e'(action_i);
      item_q.dist_mm <= distance_mm_i;
      item_q.lim_x   <= limit_x_hit_i;
      item_q.lim_y   <= limit_y_hit_i;
    end
  end

  cxg_step_core u_core (
    .cfg_i  (cfg_q),
    .st_i   (state_q),
    .item_i (item_q),
    .st_o   (state_d),
    .res_o  (res_d)
  );

  // gantry state commits as the beat enters the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.x_pos <= '0;
      state_q.y_pos <= '0;
      state_q.steps <= '0;
      state_q.mode  <= cxg_pkg::MODE_IDLE;
      state_q.dir   <= '0;
      state_q.awake <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // output register, valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register, payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign step_pulse_o     = res_q.pulse;
  assign motor1_dir_o     = res_q.dir1;
  assign motor2_dir_o     = res_q.dir2;
  assign drivers_awake_o  = res_q.awake;
  assign busy_res_o       = res_q.busy;
  assign command_status_o = res_q.status;
  assign x_position_o     = res_q.x_pos;
  assign y_position_o     = res_q.y_pos;

  // drivers are awake exactly while a move or homing runs
  `CXG_ASSERT(a_awake_busy, clk_i, rst_ni, state_q.awake == (state_q.mode != cxg_pkg::MODE_IDLE), "awake flag out of step with run mode")
  // a running move always has steps left
  `CXG_ASSERT(a_move_steps, clk_i, rst_ni, (state_q.mode == cxg_pkg::MODE_MOVE) |-> (state_q.steps != '0), "move mode with no steps left")
  // input side only stalls behind a full, stalled pipe
  `CXG_ASSERT_ALWAYS(a_stall_cause, clk_i, !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i), "input stalled without cause")

endmodule
`default_nettype wire

>>> dv/corexy_gantry_step_controller_checker.sv
module corexy_gantry_step_controller_checker
  import cxg_pkg::*;
(
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cxg_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [cxg_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [1:0]                         action_i,
  input  logic signed [cxg_pkg::DistW-1:0]   distance_mm_i,
  input  logic                               limit_x_hit_i,
  input  logic                               limit_y_hit_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic                               step_pulse_i,
  input  logic                               motor1_dir_i,
  input  logic                               motor2_dir_i,
  input  logic                               drivers_awake_i,
  input  logic                               busy_res_i,
  input  logic [1:0]                         command_status_i,
  input  logic signed [cxg_pkg::PosW-1:0]    x_position_i,
  input  logic signed [cxg_pkg::PosW-1:0]    y_position_i,
  output int                                 fail_count_o,
  output int                                 results_waiting_o,
  output int                                 beats_taken_o,
  output logic                               gantry_busy_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t   window;
  state_t gantry;
  res_t   expected_q [$];
  int     failures;
  int     taken_count;

  // next gantry state and the result beat it produces
  function automatic res_t advance_gantry(input item_t beat);
    res_t                r;
    logic                was_busy;
    int                  here;
    int                  lo;
    int                  hi;
    int                  target;
    int                  move_mm;
    int                  span;
    logic [StepsW-1:0]   count;
    r = '0;
    r.status = STAT_OK;
    was_busy = (gantry.mode != MODE_IDLE);
    move_mm = $signed(beat.dist_mm);
    if (beat.action != ACT_TICK) begin
      if (was_busy) begin
        r.status = STAT_IGNORED;
      end else if (beat.action == ACT_HOME) begin
        if (beat.lim_x && beat.lim_y) begin
          gantry.x_pos = '0;
          gantry.y_pos = '0;
          gantry.awake = 1'b0;
          gantry.mode  = MODE_IDLE;
        end else begin
          gantry.awake = 1'b1;
          gantry.mode  = MODE_HOME;
        end
      end else begin
        if (beat.action == ACT_MOVE_X) begin
          here = $signed(gantry.x_pos);
          lo   = $signed(window.min_x);
          hi   = $signed(window.max_x);
        end else begin
          here = $signed(gantry.y_pos);
          lo   = $signed(window.min_y);
          hi   = $signed(window.max_y);
        end
        target = here + move_mm;
        if (target > hi || target < lo) begin
          r.status = STAT_RANGE;
        end else begin
          span  = (move_mm < 0) ? -move_mm : move_mm;
          count = StepsW'((int'(window.spm) * span + 1) >> 1);
          if (beat.action == ACT_MOVE_X) begin
            gantry.x_pos = target[PosW-1:0];
            gantry.dir   = (move_mm < 0) ? DIR_X_BACK : DIR_X_FWD;
          end else begin
            gantry.y_pos = target[PosW-1:0];
            gantry.dir   = (move_mm < 0) ? DIR_Y_BACK : DIR_Y_FWD;
          end
          gantry.steps = count;
          gantry.awake = (count != '0);
          gantry.mode  = (count != '0) ? MODE_MOVE : MODE_IDLE;
        end
      end
    end else if (gantry.mode == MODE_MOVE) begin
      if (gantry.steps != '0) begin
        r.pulse = 1'b1;
        gantry.steps = gantry.steps - 1'b1;
      end
      if (gantry.steps == '0) begin
        gantry.awake = 1'b0;
        gantry.mode  = MODE_IDLE;
      end
    end else if (gantry.mode == MODE_HOME) begin
      if (!beat.lim_y) begin
        gantry.dir = DIR_HOME_Y;
        r.pulse    = 1'b1;
      end else if (!beat.lim_x) begin
        gantry.dir = DIR_HOME_X;
        r.pulse    = 1'b1;
      end else begin
        gantry.x_pos = '0;
        gantry.y_pos = '0;
        gantry.awake = 1'b0;
        gantry.mode  = MODE_IDLE;
      end
    end
    r.dir1  = gantry.dir[0];
    r.dir2  = gantry.dir[1];
    r.awake = gantry.awake;
    r.busy  = (gantry.mode != MODE_IDLE);
    r.x_pos = gantry.x_pos;
    r.y_pos = gantry.y_pos;
    return r;
  endfunction

  task automatic compare_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t  want;
    item_t beat;
    if (!rst_ni) begin
      window = '{min_x: RST_MIN_X, max_x: RST_MAX_X, min_y: RST_MIN_Y,
                 max_y: RST_MAX_Y, spm: RST_SPM};
      gantry      = '0;
      gantry.mode = MODE_IDLE;
      failures    = 0;
      taken_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_MIN_X: window.min_x = cfg_wdata_i;
          REG_MAX_X: window.max_x = cfg_wdata_i;
          REG_MIN_Y: window.min_y = cfg_wdata_i;
          REG_MAX_Y: window.max_y = cfg_wdata_i;
          REG_SPM:   window.spm   = cfg_wdata_i[SpmW-1:0];
          default: ;
        endcase
      end
      // result side first, so a beat taken this edge is never matched to it
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected", $time);
          failures++;
        end else begin
          want = expected_q.pop_front();
          compare_field("step_pulse", want.pulse, step_pulse_i);
          compare_field("motor1_dir", want.dir1, motor1_dir_i);
          compare_field("motor2_dir", want.dir2, motor2_dir_i);
          compare_field("drivers_awake", want.awake, drivers_awake_i);
          compare_field("busy_res", want.busy, busy_res_i);
          compare_field("command_status", want.status, command_status_i);
          compare_field("x_position", $signed(want.x_pos), $signed(x_position_i));
          compare_field("y_position", $signed(want.y_pos), $signed(y_position_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        beat.action  = action_e'(action_i);
        beat.dist_mm = distance_mm_i;
        beat.lim_x   = limit_x_hit_i;
        beat.lim_y   = limit_y_hit_i;
        want = advance_gantry(beat);
        taken_count++;
        expected_q.push_back(want);
      end
    end
    fail_count_o      <= failures;
    results_waiting_o <= expected_q.size();
    beats_taken_o     <= taken_count;
    gantry_busy_o     <= (gantry.mode != MODE_IDLE);
  end

endmodule

>>> dv/corexy_gantry_step_controller_test.sv
module corexy_gantry_step_controller_test;
  import cxg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // stop once this many input beats have been taken
  localparam int ItemGoal       = 1450;
  localparam int ScenarioBatch  = 25;
  localparam int GapMax         = 19;
  // receiver hold-off, long enough to fill both stages and back up the input
  localparam int LongHold       = 80;
  // spare edges waited after the last result has drained
  localparam int DrainCycles    = 8;
  localparam int CycleLimit     = 2_000_000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgAddrW-1:0]      cfg_addr_i;
  logic [CfgDataW-1:0]      cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [1:0]               action_i;
  logic signed [DistW-1:0]  distance_mm_i;
  logic                     limit_x_hit_i;
  logic                     limit_y_hit_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     step_pulse_o;
  logic                     motor1_dir_o;
  logic                     motor2_dir_o;
  logic                     drivers_awake_o;
  logic                     busy_res_o;
  logic [1:0]               command_status_o;
  logic signed [PosW-1:0]   x_position_o;
  logic signed [PosW-1:0]   y_position_o;

  int   fail_count;
  int   results_waiting;
  int   beats_taken;
  logic gantry_busy;
  int   cycle_count = 0;

  // shared between sender and receiver: idling on or off for this stretch,
  // and a one-shot request for the long receiver hold-off
  bit   gaps_on      = 1'b1;
  bit   hold_off_req = 1'b0;
  // steps per mm currently loaded, keeps the random moves short
  int   cur_spm      = RST_SPM;

  always #4 clk_i = ~clk_i;

  corexy_gantry_step_controller i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .distance_mm_i    (distance_mm_i),
    .limit_x_hit_i    (limit_x_hit_i),
    .limit_y_hit_i    (limit_y_hit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .step_pulse_o     (step_pulse_o),
    .motor1_dir_o     (motor1_dir_o),
    .motor2_dir_o     (motor2_dir_o),
    .drivers_awake_o  (drivers_awake_o),
    .busy_res_o       (busy_res_o),
    .command_status_o (command_status_o),
    .x_position_o     (x_position_o),
    .y_position_o     (y_position_o)
  );

  corexy_gantry_step_controller_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .action_i          (action_i),
    .distance_mm_i     (distance_mm_i),
    .limit_x_hit_i     (limit_x_hit_i),
    .limit_y_hit_i     (limit_y_hit_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .step_pulse_i      (step_pulse_o),
    .motor1_dir_i      (motor1_dir_o),
    .motor2_dir_i      (motor2_dir_o),
    .drivers_awake_i   (drivers_awake_o),
    .busy_res_i        (busy_res_o),
    .command_status_i  (command_status_o),
    .x_position_i      (x_position_o),
    .y_position_i      (y_position_o),
    .fail_count_o      (fail_count),
    .results_waiting_o (results_waiting),
    .beats_taken_o     (beats_taken),
    .gantry_busy_o     (gantry_busy)
  );

  // watchdog: a hung handshake or a lost result ends up here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one input beat after a random gap; returns on the accepting edge
  // with valid still high, so back-to-back beats never drop valid
  task automatic offer_beat(input action_e act, input int move_mm,
                            input bit lim_x, input bit lim_y);
    int gap;
    gap = gaps_on ? $urandom_range(0, GapMax) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    distance_mm_i <= move_mm[DistW-1:0];
    limit_x_hit_i <= lim_x;
    limit_y_hit_i <= lim_y;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and wait for every predicted result beat to come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_waiting != 0) @(posedge clk_i);
  endtask

  // tick until the gantry is idle (both limits hit ends any homing run),
  // then drain; the busy flag seen here lags one beat, hence tick first
  task automatic settle_gantry();
    do offer_beat(ACT_TICK, 0, 1'b1, 1'b1); while (gantry_busy);
    drain_results();
  endtask

  // write every register, only ever called with the block idle
  task automatic load_registers(input int lo_x, input int hi_x,
                                input int lo_y, input int hi_y, input int spm);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_MIN_X;
    cfg_wdata_i <= lo_x[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_addr_i  <= REG_MAX_X;
    cfg_wdata_i <= hi_x[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_addr_i  <= REG_MIN_Y;
    cfg_wdata_i <= lo_y[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_addr_i  <= REG_MAX_Y;
    cfg_wdata_i <= hi_y[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_addr_i  <= REG_SPM;
    cfg_wdata_i <= spm[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_spm = spm;
  endtask

  // one axis window: mostly a sensible range around zero, sometimes the
  // full span, sometimes inverted so every move along it is refused
  task automatic draw_window(output int lo, output int hi);
    int shape;
    shape = $urandom_range(0, 7);
    if (shape == 0) begin
      lo = -2048;
      hi = 2047;
    end else if (shape == 1) begin
      lo = $urandom_range(1, 300);
      hi = -int'($urandom_range(1, 300));
    end else begin
      lo = -int'($urandom_range(0, 300));
      hi = $urandom_range(0, 300);
    end
  endtask

  // move distance: full field range only where the step count stays modest
  function automatic int pick_distance(input bit wide);
    if (wide && cur_spm == 1) return int'($urandom_range(0, 2047)) - 1024;
    if (cur_spm > 8) return int'($urandom_range(0, 4)) - 2;
    return int'($urandom_range(0, 40)) - 20;
  endfunction

  // one random stretch of stimulus, mostly well-formed command sequences
  task automatic run_scenario();
    int pick;
    int n;
    bit both;
    pick = $urandom_range(0, 19);
    if (pick < 9) begin
      // move followed by a run of ticks, the odd command landing mid-move
      offer_beat($urandom_range(0, 1) ? ACT_MOVE_X : ACT_MOVE_Y,
                 pick_distance($urandom_range(0, 9) == 0),
                 $urandom_range(0, 1), $urandom_range(0, 1));
      n = $urandom_range(1, 40);
      repeat (n) begin
        if ($urandom_range(0, 11) == 0)
          offer_beat(action_e'($urandom_range(1, 3)), pick_distance(1'b0),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        else
          offer_beat(ACT_TICK, 0, $urandom_range(0, 1), $urandom_range(0, 1));
      end
    end else if (pick < 14) begin
      // homing: seek y, then x, then both switches closed
      both = ($urandom_range(0, 5) == 0);
      offer_beat(ACT_HOME, pick_distance(1'b0), both, both);
      n = $urandom_range(0, 6);
      repeat (n) offer_beat(ACT_TICK, 0, $urandom_range(0, 1), 1'b0);
      if ($urandom_range(0, 7) == 0)
        offer_beat(action_e'($urandom_range(1, 3)), pick_distance(1'b0), 1'b0, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) offer_beat(ACT_TICK, 0, 1'b0, 1'b1);
      offer_beat(ACT_TICK, 0, 1'b1, 1'b1);
    end else if (pick < 17) begin
      n = $urandom_range(1, 5);
      repeat (n) offer_beat(ACT_TICK, 0, $urandom_range(0, 1), $urandom_range(0, 1));
    end else begin
      // noise: anything at all
      offer_beat(action_e'($urandom_range(0, 3)), pick_distance(1'b1),
                 $urandom_range(0, 1), $urandom_range(0, 1));
    end
  endtask

  // result side: a random stall before each beat, the long hold-off on request
  initial begin : result_sink
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = LongHold;
      end else begin
        stall = gaps_on ? $urandom_range(0, GapMax) : 0;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    int lo_x;
    int hi_x;
    int lo_y;
    int hi_y;
    int spm;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    action_i      = ACT_TICK;
    distance_mm_i = '0;
    limit_x_hit_i = 1'b0;
    limit_y_hit_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window 0..400, 80 steps per mm
    offer_beat(ACT_TICK, 0, 1'b0, 1'b0);       // tick with nothing to do
    offer_beat(ACT_MOVE_X, 0, 1'b0, 1'b0);     // zero distance: dirs only
    offer_beat(ACT_MOVE_Y, -1, 1'b0, 1'b0);    // below min_y
    offer_beat(ACT_MOVE_X, 401, 1'b0, 1'b0);   // past max_x
    offer_beat(ACT_MOVE_Y, 1, 1'b0, 1'b0);     // forty steps
    offer_beat(ACT_TICK, 0, 1'b0, 1'b0);
    offer_beat(ACT_MOVE_X, 5, 1'b1, 1'b1);     // refused while moving
    offer_beat(ACT_HOME, 0, 1'b1, 1'b1);       // also refused while moving
    settle_gantry();

    // widest window, single step per mm: push x to where a further move would overflow
    load_registers(-2048, 2047, -2048, 2047, 1);
    offer_beat(ACT_MOVE_X, 1023, 1'b0, 1'b0);
    settle_gantry();
    offer_beat(ACT_MOVE_X, 2, 1'b0, 1'b0);     // x at 1025, one step
    offer_beat(ACT_TICK, 0, 1'b0, 1'b0);       // only step is also the last
    offer_beat(ACT_MOVE_X, 1023, 1'b0, 1'b0);  // 2048 is out, no wrap
    offer_beat(ACT_MOVE_Y, -3, 1'b0, 1'b0);    // backwards along y
    settle_gantry();
    offer_beat(ACT_MOVE_X, -1, 1'b0, 1'b0);    // backwards along x
    offer_beat(ACT_TICK, 0, 1'b0, 1'b0);

    // homing: already home, then a full y-then-x seek
    offer_beat(ACT_HOME, 0, 1'b1, 1'b1);
    offer_beat(ACT_MOVE_Y, 7, 1'b0, 1'b0);
    settle_gantry();
    offer_beat(ACT_HOME, 0, 1'b0, 1'b0);       // no step on the start beat
    offer_beat(ACT_TICK, 0, 1'b0, 1'b0);       // toward y
    offer_beat(ACT_HOME, 0, 1'b0, 1'b0);       // refused while homing
    offer_beat(ACT_TICK, 0, 1'b0, 1'b1);       // toward x
    offer_beat(ACT_TICK, 0, 1'b1, 1'b0);       // y open again
    offer_beat(ACT_TICK, 0, 1'b1, 1'b1);       // done, position zeroed
    drain_results();

    // inverted x window, degenerate y window, top steps per mm
    load_registers(5, -5, 0, 0, 255);
    offer_beat(ACT_MOVE_X, 0, 1'b0, 1'b0);     // every x move refused
    offer_beat(ACT_MOVE_Y, 0, 1'b0, 1'b0);
    offer_beat(ACT_MOVE_Y, 1, 1'b0, 1'b0);
    drain_results();
    load_registers(-2048, 2047, -2048, 2047, 255);
    offer_beat(ACT_MOVE_Y, -1, 1'b0, 1'b0);    // rounds up to 128 steps
    settle_gantry();

    // random part: fresh settings per batch, long hold-off in each
    while (beats_taken < ItemGoal) begin
      draw_window(lo_x, hi_x);
      draw_window(lo_y, hi_y);
      spm = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 255) : $urandom_range(1, 6);
      load_registers(lo_x, hi_x, lo_y, hi_y, spm);
      gaps_on      = ($urandom_range(0, 3) != 0);
      hold_off_req = 1'b1;
      repeat (ScenarioBatch) begin
        if (beats_taken < ItemGoal) run_scenario();
      end
      settle_gantry();
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/cxg_pkg.sv
hdl/cxg_step_core.sv
hdl/corexy_gantry_step_controller.sv
dv/corexy_gantry_step_controller_checker.sv
dv/corexy_gantry_step_controller_test.sv
